// ===== sv/iss_pkg.sv =====
// ---------------------------------------------------------------------------
// iss_pkg: shared types and codes for the indexed sequence store
// Request and status codes, the sequencer state type and the request and
// result records passed between the top level and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 7;

  // Request kinds.
  localparam logic [TYPE_W-1:0] REQ_READ     = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INS_HEAD = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_INS_TAIL = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_INS_POS  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] VALUE_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ST_W-1:0]         status;
    logic [CNT_OUT_W-1:0]    count;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/iss_mem.sv =====
// ---------------------------------------------------------------------------
// iss_mem: element storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module iss_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire  [AW-1:0]                waddr_i,
  input  wire  [iss_pkg::VAL_W-1:0]    wdata_i,
  input  wire  [AW-1:0]                raddr_i,
  output logic [iss_pkg::VAL_W-1:0]    rdata_o
);

  logic [iss_pkg::VAL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/iss_seq.sv =====
// ---------------------------------------------------------------------------
// iss_seq: request sequencer
// Decodes a request, checks its position against the element count and
// walks the store one element per cycle to open or close a gap.
// ---------------------------------------------------------------------------
`default_nettype none

module iss_seq #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CNT_W    = 7
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           req_valid_i,
  input  iss_pkg::req_t                 req_i,
  output logic                          req_ready_o,
  output logic                          res_valid_o,
  output iss_pkg::res_t                 res_o,
  input  wire                           res_ready_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [iss_pkg::VAL_W-1:0]     mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  wire  [iss_pkg::VAL_W-1:0]     mem_rdata_i
);

  localparam int unsigned CMP_W = (CNT_W > iss_pkg::POS_W) ? CNT_W : iss_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  iss_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       pend_q, pend_d;
  logic [AW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]              wr_addr_q, wr_addr_d;
  logic [AW-1:0]              ip_q, ip_d;
  logic [CNT_W-1:0]           left_q, left_d;
  logic                       ins_q, ins_d;
  logic [iss_pkg::VAL_W-1:0]  val_q, val_d;
  logic [iss_pkg::VAL_W-1:0]  vout_q, vout_d;
  logic [iss_pkg::ST_W-1:0]   st_q, st_d;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] ip_ext;
  logic             accept;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(req_i.position);
  assign accept  = req_valid_i && (state_q == iss_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = pend_q;
    rd_ptr_d    = rd_ptr_q;
    wr_addr_d   = wr_addr_q;
    ip_d        = ip_q;
    left_d      = left_q;
    ins_d       = ins_q;
    val_d       = val_q;
    vout_d      = vout_q;
    st_d        = st_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_addr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rd_ptr_q;
    ip_ext      = '0;

    unique case (state_q)
      iss_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        mem_raddr_o = pos_ext[AW-1:0];
        if (accept) begin
          vout_d = '0;
          st_d   = iss_pkg::ST_DONE;
          val_d  = req_i.value;
          unique case (req_i.kind)
            iss_pkg::REQ_READ: begin
              if (pos_ext < cnt_ext) begin
                state_d = iss_pkg::S_READ;
              end else begin
                vout_d  = iss_pkg::VALUE_NONE;
                st_d    = iss_pkg::ST_RANGE;
                state_d = iss_pkg::S_FIN;
              end
            end
            iss_pkg::REQ_INS_HEAD, iss_pkg::REQ_INS_TAIL, iss_pkg::REQ_INS_POS: begin
              if (req_i.kind == iss_pkg::REQ_INS_HEAD) begin
                ip_ext = '0;
              end else if (req_i.kind == iss_pkg::REQ_INS_TAIL) begin
                ip_ext = cnt_ext;
              end else begin
                ip_ext = pos_ext;
              end
              if (req_i.kind == iss_pkg::REQ_INS_POS && pos_ext > cnt_ext) begin
                st_d    = iss_pkg::ST_RANGE;
                state_d = iss_pkg::S_FIN;
              end else if (count_q == CAP_CNT) begin
                st_d    = iss_pkg::ST_FULL;
                state_d = iss_pkg::S_FIN;
              end else begin
                // Elements from the insertion point up to the tail move up by one.
                ins_d    = 1'b1;
                ip_d     = ip_ext[AW-1:0];
                left_d   = CNT_W'(cnt_ext - ip_ext);
                rd_ptr_d = AW'(cnt_ext - CMP_W'(1));
                pend_d   = 1'b0;
                state_d  = iss_pkg::S_SHIFT;
              end
            end
            iss_pkg::REQ_DELETE: begin
              if (pos_ext < cnt_ext) begin
                // Elements behind the deleted one move down by one.
                ins_d    = 1'b0;
                left_d   = CNT_W'(cnt_ext - pos_ext - CMP_W'(1));
                rd_ptr_d = AW'(pos_ext + CMP_W'(1));
                pend_d   = 1'b0;
                state_d  = iss_pkg::S_SHIFT;
              end else begin
                st_d    = iss_pkg::ST_RANGE;
                state_d = iss_pkg::S_FIN;
              end
            end
            default: begin
              st_d    = iss_pkg::ST_RANGE;
              state_d = iss_pkg::S_FIN;
            end
          endcase
        end
      end

      iss_pkg::S_READ: begin
        vout_d  = mem_rdata_i;
        state_d = iss_pkg::S_FIN;
      end

      iss_pkg::S_SHIFT: begin
        // A read is issued each cycle and its data is written back in the next
        // cycle, one place further along.
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (left_q != '0) begin
          left_d    = left_q - CNT_W'(1);
          pend_d    = 1'b1;
          rd_ptr_d  = ins_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
          wr_addr_d = ins_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (ins_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = ip_q;
              mem_wdata_o = val_q;
              count_d     = count_q + CNT_W'(1);
            end else begin
              count_d = count_q - CNT_W'(1);
            end
            state_d = iss_pkg::S_FIN;
          end
        end
      end

      iss_pkg::S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = iss_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = iss_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.value  = vout_q;
    res_o.status = st_q;
    res_o.count  = cnt_ext[iss_pkg::CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iss_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    wr_addr_q <= wr_addr_d;
    ip_q      <= ip_d;
    left_q    <= left_d;
    ins_q     <= ins_d;
    val_q     <= val_d;
    vout_q    <= vout_d;
    st_q      <= st_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("element count above capacity");

  a_count_moves_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != iss_pkg::S_SHIFT) |=> $stable(count_q))
    else $error("element count changed outside a shift");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iss_pkg::S_FIN && st_q == iss_pkg::ST_FULL) |-> (count_q == CAP_CNT))
    else $error("full status with room left");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iss_pkg::S_FIN && !res_ready_i) |=> (state_q == iss_pkg::S_FIN))
    else $error("result dropped before it was taken");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (CMP_W'(mem_waddr_o) < CMP_W'(CAPACITY)))
    else $error("store write beyond capacity");

endmodule

`default_nettype wire

// ===== sv/indexed_sequence_store_core.sv =====
// A read passes from idle through the read and finish states to the output
// register; an insert or delete passes through the shift state, where the
// store is walked one element per cycle, and a rejected request goes
// straight to the finish state. A new request is taken only once the last
// result has left the finish state for the output register.
// Reset clears the element count and the handshake state; the store itself
// keeps whatever it holds and needs no clearing pass.
// ---------------------------------------------------------------------------
// indexed_sequence_store_core: ordered store of signed 32-bit values
// Reads, inserts and deletes by position with range and full checks, with a
// one-entry output register on the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_store_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // [6:0] position, [38:7] value_in, [39] zero
  input  wire  [2:0]  s_axis_tuser,  // [2:0] req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] value_out, [38:32] count_out, [39] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  iss_pkg::req_t req;
  iss_pkg::res_t res;
  iss_pkg::res_t out_q;
  logic          out_valid_q;
  logic          res_valid;
  logic          out_free;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [iss_pkg::VAL_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [iss_pkg::VAL_W-1:0] mem_rdata;

  assign req.kind     = s_axis_tuser;
  assign req.position = s_axis_tdata[6:0];
  assign req.value    = s_axis_tdata[38:7];

  // The next request may be taken while an earlier result still waits here.
  assign out_free = !out_valid_q || m_axis_tready;

  iss_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (out_free),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iss_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.value};
  assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire
